FILE: src/mits_pkg.sv
// Shared types and codes for the min-index topological sort block.
package mits_pkg;

	localparam logic [1:0] KIND_MAP  = 2'd0;
	localparam logic [1:0] KIND_LINK = 2'd1;
	localparam logic [1:0] KIND_RUN  = 2'd2;
	localparam logic [1:0] KIND_NOP  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EP    = 2'd1;
	localparam logic [1:0] ST_LEAF  = 2'd2;
	localparam logic [1:0] ST_CYCLE = 2'd3;

	localparam logic REG_LEAF_COUNT     = 1'b0;
	localparam logic REG_ENDPOINT_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] index_a;
		logic [7:0] index_b;
		logic [7:0] mapped_leaf;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       entry_valid;
		logic [5:0] slot;
		logic [5:0] scheduled_leaf;
		logic       last;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_LINK_RD,
		S_LINK_MAP,
		S_LINK_ROW,
		S_INIT,
		S_PICK,
		S_ROW,
		S_SCAN,
		S_DEC,
		S_CHECK,
		S_EMIT_RD,
		S_EMIT,
		S_ONE
	} state_t;

endpackage

FILE: src/mits_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module mits_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/min_index_topological_sort.sv
// Top level: APB registers, map/edge/degree/order memories and the sort sequencer.
// Map item: busy stays low. Link item: busy through range check, map reads, edge row
// read-modify-write and degree increment. Run: busy through a degree scan, a pick of each
// scheduled leaf with its edges, an order read, one result per cycle (a single status
// result on error, cycle or empty graph), then a sweep that clears rows and degrees.
// Reset: asynchronous; the same sweep runs first. Results cannot be stalled by the receiver.
module min_index_topological_sort #(
	parameter int MAX_LEAVES    = 64,
	parameter int MAX_ENDPOINTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mits_pkg::item_t       item,
	output logic                  strobe,
	output mits_pkg::result_t     result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	localparam int LW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
	localparam int EW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
	localparam int CW = $clog2(MAX_LEAVES + 1);
	localparam int MD = (MAX_LEAVES > 1) ? MAX_LEAVES : 2;
	localparam int ED = (MAX_ENDPOINTS > 1) ? MAX_ENDPOINTS : 2;

	logic [6:0] leaf_count_q;
	logic [8:0] endpoint_count_q;
	logic [CW-1:0] nl;
	logic [9:0] ne;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q     <= '0;
			endpoint_count_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == mits_pkg::REG_LEAF_COUNT) begin
				leaf_count_q <= pwdata[6:0];
			end else begin
				endpoint_count_q <= pwdata[8:0];
			end
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == mits_pkg::REG_LEAF_COUNT) begin
			prdata[6:0] = leaf_count_q;
		end else begin
			prdata[8:0] = endpoint_count_q;
		end
	end
	assign nl = (32'(leaf_count_q) > MAX_LEAVES) ? CW'(MAX_LEAVES) : CW'(leaf_count_q);
	assign ne = (32'(endpoint_count_q) > MAX_ENDPOINTS) ? 10'(MAX_ENDPOINTS)
		: 10'(endpoint_count_q);

	// memories
	logic          map_we;
	logic [EW-1:0] map_wa, map_ra;
	logic [7:0]    map_wd, map_rd;
	logic          row_we;
	logic [LW-1:0] row_wa, row_ra;
	logic [MD-1:0] row_wd, row_rd;
	logic          deg_we;
	logic [LW-1:0] deg_wa, deg_ra;
	logic [6:0]    deg_wd, deg_rd;
	logic          ord_we;
	logic [LW-1:0] ord_wa, ord_ra;
	logic [5:0]    ord_wd, ord_rd;

	mits_ram #(.WIDTH(8), .DEPTH(ED)) u_map (.clk, .we(map_we), .waddr(map_wa),
		.wdata(map_wd), .raddr(map_ra), .rdata(map_rd));
	mits_ram #(.WIDTH(MD), .DEPTH(MD)) u_row (.clk, .we(row_we), .waddr(row_wa),
		.wdata(row_wd), .raddr(row_ra), .rdata(row_rd));
	mits_ram #(.WIDTH(7), .DEPTH(MD)) u_deg (.clk, .we(deg_we), .waddr(deg_wa),
		.wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd));
	mits_ram #(.WIDTH(6), .DEPTH(MD)) u_ord (.clk, .we(ord_we), .waddr(ord_wa),
		.wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));

	mits_pkg::state_t state_q, state_d;
	mits_pkg::item_t  item_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] ocnt_q, ocnt_d;
	logic [1:0]    err_q, err_d;
	logic [MD-1:0] ready_q, ready_d;
	logic [MD-1:0] rowv_q, rowv_d;
	logic [7:0]    pmap_q, pmap_d;
	logic [LW-1:0] cur_q, cur_d;
	logic          run_q, run_d;
	logic [LW-1:0] low_rdy, low_row;

	always_comb begin
		low_rdy = '0;
		for (int i = MD - 1; i >= 0; i--) begin
			if (ready_q[i]) begin
				low_rdy = LW'(i);
			end
		end
		low_row = '0;
		for (int i = MD - 1; i >= 0; i--) begin
			if (rowv_q[i]) begin
				low_row = LW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mits_pkg::S_CLEAR;
			cnt_q   <= '0;
			ocnt_q  <= '0;
			err_q   <= '0;
			ready_q <= '0;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ocnt_q  <= ocnt_d;
			err_q   <= err_d;
			ready_q <= ready_d;
			run_q   <= run_d;
		end
	end
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
		rowv_q <= rowv_d;
		pmap_q <= pmap_d;
		cur_q  <= cur_d;
	end

	assign busy = (state_q != mits_pkg::S_IDLE);

	always_comb begin
		logic [MD-1:0] nrow;
		nrow = '0;
		state_d = state_q;
		cnt_d = cnt_q; ocnt_d = ocnt_q; err_d = err_q; ready_d = ready_q;
		rowv_d = rowv_q; pmap_d = pmap_q; cur_d = cur_q; run_d = run_q;
		map_we = 1'b0; map_wa = EW'(item.index_a); map_wd = item.mapped_leaf;
		map_ra = EW'(item.index_a);
		row_we = 1'b0; row_wa = cnt_q[LW-1:0]; row_wd = '0; row_ra = '0;
		deg_we = 1'b0; deg_wa = cnt_q[LW-1:0]; deg_wd = '0; deg_ra = cnt_q[LW-1:0];
		ord_we = 1'b0; ord_wa = ocnt_q[LW-1:0]; ord_wd = '0; ord_ra = cnt_q[LW-1:0];
		strobe = 1'b0;
		result = '0;
		unique case (state_q)
			mits_pkg::S_IDLE: begin
				if (start) begin
					unique case (item.kind)
						mits_pkg::KIND_MAP: begin
							map_we = (32'(item.index_a) < MAX_ENDPOINTS);
						end
						mits_pkg::KIND_LINK: begin
							if (err_q == mits_pkg::ST_OK) begin
								state_d = mits_pkg::S_LINK_RD;
							end
						end
						mits_pkg::KIND_RUN: begin
							cnt_d = '0;
							ready_d = '0;
							ocnt_d = '0;
							if (err_q != mits_pkg::ST_OK || nl == '0) begin
								state_d = mits_pkg::S_ONE;
							end else begin
								state_d = mits_pkg::S_INIT;
							end
						end
						default: ;
					endcase
				end
			end
			mits_pkg::S_LINK_RD: begin
				if (10'(item_q.index_a) >= ne || 10'(item_q.index_b) >= ne) begin
					err_d = mits_pkg::ST_EP;
					state_d = mits_pkg::S_IDLE;
				end else begin
					map_ra = EW'(item_q.index_a);
					state_d = mits_pkg::S_LINK_MAP;
				end
			end
			mits_pkg::S_LINK_MAP: begin
				pmap_d = map_rd;
				map_ra = EW'(item_q.index_b);
				row_ra = map_rd[LW-1:0];
				state_d = mits_pkg::S_LINK_ROW;
			end
			mits_pkg::S_LINK_ROW: begin
				// map_rd is the consumer leaf, row_rd the producer's row
				deg_ra = map_rd[LW-1:0];
				if (9'(pmap_q) >= 9'(nl) || 9'(map_rd) >= 9'(nl)) begin
					err_d = mits_pkg::ST_LEAF;
					state_d = mits_pkg::S_IDLE;
				end else if (row_rd[map_rd[LW-1:0]]) begin
					state_d = mits_pkg::S_IDLE;
				end else begin
					row_we = 1'b1;
					row_wa = pmap_q[LW-1:0];
					row_wd = row_rd;
					row_wd[map_rd[LW-1:0]] = 1'b1;
					cur_d = map_rd[LW-1:0];
					state_d = mits_pkg::S_CHECK;
					run_d = 1'b0;
				end
			end
			mits_pkg::S_CHECK: begin
				// link: write incremented degree; degree read was issued last cycle
				deg_we = 1'b1;
				deg_wa = cur_q;
				deg_wd = deg_rd + 7'd1;
				state_d = mits_pkg::S_IDLE;
			end
			mits_pkg::S_INIT: begin
				// scan degrees: each read is registered and tested while the next read is issued
				deg_ra = cnt_q[LW-1:0];
				if (run_q) begin
					if (deg_rd == '0) begin
						ready_d[cur_q] = 1'b1;
					end
				end
				cur_d = cnt_q[LW-1:0];
				if (cnt_q == nl) begin
					run_d = 1'b0;
					state_d = mits_pkg::S_PICK;
				end else begin
					run_d = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			mits_pkg::S_PICK: begin
				if (ready_q == '0 || ocnt_q == nl) begin
					cnt_d = '0;
					state_d = (ocnt_q == nl) ? mits_pkg::S_EMIT_RD : mits_pkg::S_ONE;
				end else begin
					ready_d[low_rdy] = 1'b0;
					ord_we = 1'b1;
					ord_wd = 6'(low_rdy);
					ocnt_d = ocnt_q + 1'b1;
					row_ra = low_rdy;
					state_d = mits_pkg::S_ROW;
				end
			end
			mits_pkg::S_ROW: begin
				for (int i = 0; i < MD; i++) begin
					nrow[i] = row_rd[i] && (32'(i) < 32'(nl));
				end
				rowv_d = nrow;
				state_d = mits_pkg::S_SCAN;
			end
			mits_pkg::S_SCAN: begin
				if (rowv_q == '0) begin
					state_d = mits_pkg::S_PICK;
				end else begin
					deg_ra = low_row;
					cur_d = low_row;
					rowv_d[low_row] = 1'b0;
					state_d = mits_pkg::S_DEC;
				end
			end
			mits_pkg::S_DEC: begin
				if (deg_rd != '0) begin
					deg_we = 1'b1;
					deg_wa = cur_q;
					deg_wd = deg_rd - 7'd1;
					if (deg_rd == 7'd1) begin
						ready_d[cur_q] = 1'b1;
					end
				end
				state_d = mits_pkg::S_SCAN;
			end
			mits_pkg::S_EMIT_RD: begin
				ord_ra = cnt_q[LW-1:0];
				state_d = mits_pkg::S_EMIT;
			end
			mits_pkg::S_EMIT: begin
				strobe = 1'b1;
				result.status = mits_pkg::ST_OK;
				result.entry_valid = 1'b1;
				result.slot = 6'(cnt_q);
				result.scheduled_leaf = ord_rd;
				result.last = (cnt_q + 1'b1 == nl);
				ord_ra = LW'(cnt_q + 1'b1);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q + 1'b1 == nl) begin
					cnt_d = '0;
					state_d = mits_pkg::S_CLEAR;
				end
			end
			mits_pkg::S_ONE: begin
				strobe = 1'b1;
				result.status = (err_q != mits_pkg::ST_OK) ? err_q
					: ((nl == '0) ? mits_pkg::ST_OK : mits_pkg::ST_CYCLE);
				result.last = 1'b1;
				cnt_d = '0;
				state_d = mits_pkg::S_CLEAR;
			end
			mits_pkg::S_CLEAR: begin
				// sweep edge rows and degrees back to zero
				row_we = 1'b1;
				deg_we = 1'b1;
				err_d = mits_pkg::ST_OK;
				ready_d = '0;
				if (32'(cnt_q) == MAX_LEAVES - 1) begin
					cnt_d = '0;
					state_d = mits_pkg::S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = mits_pkg::S_IDLE;
		endcase
	end
endmodule

FILE: tb/min_index_topological_sort_tb.sv
// Testbench for the min-index topological sort block: directed and random jobs checked against a predictor.
module min_index_topological_sort_tb;

	// Holds expected schedule results and checks each strobed result against the oldest one.
	class schedule_board;
		logic [6:0] leaves;
		logic [8:0] endpoints;
		logic [7:0] leaf_of[256];
		logic [63:0] succ[64];
		int         indeg[64];
		logic [1:0] err;
		mits_pkg::result_t pending[$];
		int         errors;

		function void clear_job();
			for (int i = 0; i < 256; i++) begin
				leaf_of[i] = '0;
			end
			for (int i = 0; i < 64; i++) begin
				succ[i] = '0;
				indeg[i] = 0;
			end
			err = mits_pkg::ST_OK;
		endfunction

		function void push_result(logic [1:0] st, logic v, int s, int lf, logic lst);
			mits_pkg::result_t r;
			r.status = st;
			r.entry_valid = v;
			r.slot = s[5:0];
			r.scheduled_leaf = lf[5:0];
			r.last = lst;
			pending = {pending, r};
		endfunction

		function void sort_job();
			int n, cnt, pick;
			logic [63:0] ready;
			int order[64];
			n = (leaves > 64) ? 64 : leaves;
			if (err != mits_pkg::ST_OK) begin
				push_result(err, 0, 0, 0, 1);
				return;
			end
			if (n == 0) begin
				push_result(mits_pkg::ST_OK, 0, 0, 0, 1);
				return;
			end
			ready = '0;
			for (int i = 0; i < n; i++)
				if (indeg[i] == 0) ready[i] = 1;
			cnt = 0;
			while (ready != 0 && cnt < n) begin
				pick = 0;
				while (!ready[pick]) pick++;
				ready[pick] = 0;
				order[cnt] = pick;
				cnt++;
				for (int j = 0; j < n; j++)
					if (succ[pick][j] && indeg[j] != 0) begin
						indeg[j]--;
						if (indeg[j] == 0) ready[j] = 1;
					end
			end
			if (cnt != n) push_result(mits_pkg::ST_CYCLE, 0, 0, 0, 1);
			else
				for (int k = 0; k < n; k++)
					push_result(mits_pkg::ST_OK, 1, k, order[k], k == n - 1);
		endfunction

		function void note_item(mits_pkg::item_t it);
			int ne, nl, p, c;
			ne = (endpoints > 256) ? 256 : endpoints;
			nl = (leaves > 64) ? 64 : leaves;
			case (it.kind)
				mits_pkg::KIND_MAP: begin
					leaf_of[it.index_a] = it.mapped_leaf;
				end
				mits_pkg::KIND_LINK: begin
					if (err == mits_pkg::ST_OK) begin
						if (it.index_a >= ne || it.index_b >= ne) err = mits_pkg::ST_EP;
						else begin
							p = leaf_of[it.index_a];
							c = leaf_of[it.index_b];
							if (p >= nl || c >= nl) err = mits_pkg::ST_LEAF;
							else if (!succ[p][c]) begin
								succ[p][c] = 1;
								indeg[c] = (indeg[c] + 1) & 127;
							end
						end
					end
				end
				mits_pkg::KIND_RUN: begin
					sort_job();
					clear_job();
				end
				default: ;
			endcase
		endfunction

		function void check_result(mits_pkg::result_t got);
			mits_pkg::result_t exp_r;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, actual %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.entry_valid !== exp_r.entry_valid) begin
				$error("entry_valid: expected %0d, actual %0d", exp_r.entry_valid,
					got.entry_valid);
				errors++;
			end
			if (got.slot !== exp_r.slot) begin
				$error("slot: expected %0d, actual %0d", exp_r.slot, got.slot);
				errors++;
			end
			if (got.scheduled_leaf !== exp_r.scheduled_leaf) begin
				$error("scheduled_leaf: expected %0d, actual %0d", exp_r.scheduled_leaf,
					got.scheduled_leaf);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("last: expected %0d, actual %0d", exp_r.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	mits_pkg::item_t   item;
	logic        strobe;
	mits_pkg::result_t result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	schedule_board board;
	int          gap_pct;
	int          item_total;

	min_index_topological_sort DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.strobe(strobe), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) board.check_result(result);
	end

	task automatic write_reg(logic idx, logic [31:0] value);
		start <= 0;
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == mits_pkg::REG_LEAF_COUNT) board.leaves = value[6:0];
		else board.endpoints = value[8:0];
	endtask

	// Wait out all expected results, then let any trailing link finish.
	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Leave start high after a transaction; the next send either idles or replaces it.
	task automatic send(logic [1:0] k, logic [7:0] a, logic [7:0] b, logic [7:0] m);
		mits_pkg::item_t it;
		it.kind = k;
		it.index_a = a;
		it.index_b = b;
		it.mapped_leaf = m;
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		item <= it;
		do @(posedge clk); while (busy);
		board.note_item(it);
		item_total++;
	endtask

	// Map leaves to endpoints one to one, then add random links, forward ones unless allow_back.
	task automatic random_job(int nl, int ne, int links, bit allow_back);
		int p, c;
		for (int i = 0; i < ne && i < 256; i++)
			send(mits_pkg::KIND_MAP, i[7:0], 8'($urandom),
				(i < nl) ? i[7:0] : 8'($urandom_range(63)));
		for (int i = 0; i < links; i++) begin
			p = $urandom_range(nl - 1);
			c = $urandom_range(nl - 1);
			if (!allow_back && p > c) begin
				int t = p; p = c; c = t;
			end
			if (!allow_back && p == c) continue;
			send(mits_pkg::KIND_LINK, p[7:0], c[7:0], 8'($urandom));
		end
		if ($urandom_range(9) == 0)
			send(mits_pkg::KIND_LINK, 8'($urandom), 8'($urandom), 8'($urandom));
		send(mits_pkg::KIND_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		board = new();
		board.clear_job();
		board.leaves = 0;
		board.endpoints = 0;
		board.errors = 0;
		item_total = 0;
		gap_pct = 0;
		arst_n = 0;
		start = 0;
		item = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Empty graph, then extremes of kind and field values.
		send(mits_pkg::KIND_RUN, 8'hFF, 8'hFF, 8'hFF);
		send(mits_pkg::KIND_NOP, 8'hAA, 8'h55, 8'hFF);
		drain();
		write_reg(mits_pkg::REG_LEAF_COUNT, 32'd4);
		write_reg(mits_pkg::REG_ENDPOINT_COUNT, 32'd256);
		send(mits_pkg::KIND_MAP, 8'd0, 8'hFF, 8'd3);
		send(mits_pkg::KIND_MAP, 8'd255, 8'h00, 8'd0);
		send(mits_pkg::KIND_MAP, 8'd1, 8'h00, 8'd1);
		send(mits_pkg::KIND_LINK, 8'd0, 8'd255, 8'd0);
		send(mits_pkg::KIND_LINK, 8'd0, 8'd255, 8'd0);
		send(mits_pkg::KIND_LINK, 8'd1, 8'd0, 8'd0);
		send(mits_pkg::KIND_RUN, 8'd0, 8'd0, 8'd0);
		// Cycle.
		send(mits_pkg::KIND_MAP, 8'd0, 8'd0, 8'd1);
		send(mits_pkg::KIND_MAP, 8'd1, 8'd0, 8'd2);
		send(mits_pkg::KIND_LINK, 8'd0, 8'd1, 8'd0);
		send(mits_pkg::KIND_LINK, 8'd1, 8'd0, 8'd0);
		send(mits_pkg::KIND_RUN, 8'd0, 8'd0, 8'd0);
		// Leaf out of range, then a later link that must be ignored.
		send(mits_pkg::KIND_MAP, 8'd2, 8'd0, 8'hFF);
		send(mits_pkg::KIND_LINK, 8'd2, 8'd2, 8'd0);
		send(mits_pkg::KIND_LINK, 8'd0, 8'd0, 8'd0);
		send(mits_pkg::KIND_RUN, 8'd0, 8'd0, 8'd0);
		drain();
		// Endpoint out of range, and shrink leaf count mid-job.
		write_reg(mits_pkg::REG_ENDPOINT_COUNT, 32'd2);
		send(mits_pkg::KIND_MAP, 8'd0, 8'd0, 8'd3);
		send(mits_pkg::KIND_MAP, 8'd1, 8'd0, 8'd0);
		send(mits_pkg::KIND_LINK, 8'd0, 8'd1, 8'd0);
		drain();
		write_reg(mits_pkg::REG_LEAF_COUNT, 32'd2);
		send(mits_pkg::KIND_RUN, 8'd0, 8'd0, 8'd0);
		send(mits_pkg::KIND_LINK, 8'd2, 8'd0, 8'd0);
		send(mits_pkg::KIND_RUN, 8'd0, 8'd0, 8'd0);
		drain();
		write_reg(mits_pkg::REG_LEAF_COUNT, 32'd127);
		write_reg(mits_pkg::REG_ENDPOINT_COUNT, 32'd511);
		random_job(64, 64, 20, 0);
		drain();

		// Random phases: sender gaps, then none.
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 24 : (phase == 1) ? 49 : 0;
			for (int j = 0; j < 12; j++) begin
				int nl, ne;
				if (item_total >= 130 + 80 * (phase + 1)) break;
				nl = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 10);
				ne = nl + $urandom_range(0, 4);
				write_reg(mits_pkg::REG_LEAF_COUNT, nl);
				write_reg(mits_pkg::REG_ENDPOINT_COUNT, ne);
				random_job(nl, ne, $urandom_range(0, 2 * nl), $urandom_range(3) == 0);
				drain();
			end
			drain();
		end
		write_reg(mits_pkg::REG_LEAF_COUNT, 32'd0);
		write_reg(mits_pkg::REG_ENDPOINT_COUNT, 32'd0);
		send(mits_pkg::KIND_LINK, 8'd0, 8'd0, 8'd0);
		send(mits_pkg::KIND_RUN, 8'd0, 8'd0, 8'd0);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
